### src/smoothstep_servo_sweep_defines.svh
// Assertion macros shared by the sweep RTL.
`ifndef SMOOTHSTEP_SERVO_SWEEP_DEFINES_SVH
`define SMOOTHSTEP_SERVO_SWEEP_DEFINES_SVH

`ifndef SYNTHESIS
`define SMSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMSS_INVARIANT(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define SMSS_ASSERT(label, clk, rst_n, prop, msg)
`define SMSS_INVARIANT(label, clk, rst_n, expr, msg)
`endif

`endif

### src/smss_pkg.sv
package smss_pkg;

  localparam int EASE_BITS  = 12;
  localparam int EASE_SCALE = 1 << EASE_BITS;

  localparam int FC_W    = 10;
  localparam int PULSE_W = 12;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // phase*scale + fc/2 fits in FC_W + EASE_BITS bits
  localparam int NUM_W     = FC_W + EASE_BITS;
  localparam int T_W       = EASE_BITS + 1;
  localparam int TT_W      = 2 * EASE_BITS + 1;
  localparam int W_W       = EASE_BITS + 2;
  localparam int PROD_W    = TT_W + W_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [FC_W-1:0]    FRAME_COUNT_RST = FC_W'(100);
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = PULSE_W'(500);
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = PULSE_W'(2500);

  typedef enum logic [1:0] {
    REG_FRAME_COUNT = 2'd0,
    REG_MIN_PULSE   = 2'd1,
    REG_MAX_PULSE   = 2'd2
  } reg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_SQ    = 8'b0000_0100,
    ST_CUBE  = 8'b0000_1000,
    ST_SCALE = 8'b0001_0000,
    ST_RANGE = 8'b0010_0000,
    ST_PULSE = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [FC_W-1:0]    frame_count;
    logic [PULSE_W-1:0] min_pulse_us;
    logic [PULSE_W-1:0] max_pulse_us;
  } smss_cfg_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic mul_sq;
    logic mul_cube;
    logic scale;
    logic mul_range;
    logic pulse;
    logic load_out;
  } smss_cmd_t;

endpackage

### src/smoothstep_servo_sweep.sv
// Servo sweep with smoothstep easing, one pulse beat per tick beat.
// A tick beat runs through the bit-serial divider, then through the shared 25x14
// multiplier and rounding steps; no new tick beat is accepted until its result is loaded,
// and loading waits while the output is stalled.
// Reset (synchronous, rst_n low): registers to 100/500/2500, phase 0, sweeping up.
// Beats with tick low are accepted and give no result.
module smoothstep_servo_sweep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [smss_pkg::PULSE_W-1:0]  out_hip_pulse_us,
  output logic [smss_pkg::PULSE_W-1:0]  out_thigh_pulse_us,
  output logic [smss_pkg::PULSE_W-1:0]  out_calf_pulse_us,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [smss_pkg::ADDR_W-1:0]   paddr,
  input  logic [smss_pkg::DATA_W-1:0]   pwdata,
  output logic [smss_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import smss_pkg::*;

  smss_cfg_t cfg;
  smss_cmd_t cmd;

  smss_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_tick   (in_tick),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  smss_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .hip_pulse_us   (out_hip_pulse_us),
    .thigh_pulse_us (out_thigh_pulse_us),
    .calf_pulse_us  (out_calf_pulse_us)
  );

endmodule

### src/smss_regs.sv
module smss_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smss_pkg::ADDR_W-1:0]  paddr,
  input  logic [smss_pkg::DATA_W-1:0]  pwdata,
  output logic [smss_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output smss_pkg::smss_cfg_t          cfg
);
  import smss_pkg::*;

  logic [FC_W-1:0]    fc_r, fc_nxt;
  logic [PULSE_W-1:0] min_r, min_nxt;
  logic [PULSE_W-1:0] max_r, max_nxt;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    fc_nxt  = fc_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (wr_en) begin
      case (idx)
        REG_FRAME_COUNT: fc_nxt  = pwdata[FC_W-1:0];
        REG_MIN_PULSE:   min_nxt = pwdata[PULSE_W-1:0];
        REG_MAX_PULSE:   max_nxt = pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r  <= FRAME_COUNT_RST;
      min_r <= MIN_PULSE_RST;
      max_r <= MAX_PULSE_RST;
    end else begin
      fc_r  <= fc_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_COUNT: prdata = DATA_W'(fc_r);
      REG_MIN_PULSE:   prdata = DATA_W'(min_r);
      REG_MAX_PULSE:   prdata = DATA_W'(max_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.frame_count  = fc_r;
  assign cfg.min_pulse_us = min_r;
  assign cfg.max_pulse_us = max_r;

endmodule

### src/smss_ctrl.sv
`include "smoothstep_servo_sweep_defines.svh"

module smss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_tick,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output smss_pkg::smss_cmd_t  cmd
);
  import smss_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        // a beat with tick low is taken and dropped
        if (in_valid && in_tick) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SQ;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQ: begin
        cmd.mul_sq = 1'b1;
        state_nxt  = ST_CUBE;
      end
      ST_CUBE: begin
        cmd.mul_cube = 1'b1;
        state_nxt    = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_RANGE;
      end
      ST_RANGE: begin
        cmd.mul_range = 1'b1;
        state_nxt     = ST_PULSE;
      end
      ST_PULSE: begin
        cmd.pulse = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `SMSS_ASSERT(a_tick_starts_div, clk, rst_n, in_valid && !in_stall && in_tick |=> state_r == ST_DIV, "tick beat did not start the divider")
  `SMSS_ASSERT(a_div_full_length, clk, rst_n, state_r == ST_SQ |-> $past(state_r == ST_DIV) && $past(cnt_r) == CNT_W'(DIV_STEPS - 1), "divider left early")
  `SMSS_INVARIANT(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(DIV_STEPS - 1), "step counter overran")

endmodule

### src/smss_dp.sv
`include "smoothstep_servo_sweep_defines.svh"

module smss_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smss_pkg::smss_cfg_t           cfg,
  input  smss_pkg::smss_cmd_t           cmd,
  output logic [smss_pkg::PULSE_W-1:0]  hip_pulse_us,
  output logic [smss_pkg::PULSE_W-1:0]  thigh_pulse_us,
  output logic [smss_pkg::PULSE_W-1:0]  calf_pulse_us
);
  import smss_pkg::*;

  // sweep state
  logic [FC_W-1:0]    phase_r, phase_nxt;
  logic               down_r, down_nxt;
  // per-beat working registers
  logic [FC_W-1:0]    fc_r;
  logic [PULSE_W-1:0] lo_r, hi_r;
  logic [NUM_W-1:0]   num_r;
  logic [FC_W-1:0]    rem_r;
  logic [PROD_W-1:0]  prod_r;
  logic [T_W-1:0]     sm_r;
  logic [PULSE_W-1:0] pulse_r;
  logic [PULSE_W-1:0] hip_r, thigh_r;

  logic [FC_W-1:0]    fc_eff, phase_c;
  logic [PULSE_W-1:0] hi_eff, span;
  logic [FC_W:0]      rem_sh;
  logic               rem_ge;
  logic [T_W-1:0]     t;
  logic [TT_W-1:0]    mul_a;
  logic [W_W-1:0]     mul_b;
  logic [PROD_W-1:0]  prod_rnd_sm, prod_rnd_pulse;

  assign fc_eff  = (cfg.frame_count == '0) ? FC_W'(1) : cfg.frame_count;
  assign hi_eff  = (cfg.max_pulse_us < cfg.min_pulse_us) ? cfg.min_pulse_us
                                                          : cfg.max_pulse_us;
  assign phase_c = (phase_r > fc_eff) ? fc_eff : phase_r;

  // restoring divider, one quotient bit per step; quotient shifts into num_r
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, fc_r});
  assign t      = num_r[T_W-1:0];
  assign span   = hi_r - lo_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_sq) begin
      mul_a = TT_W'(t);
      mul_b = W_W'(t);
    end else if (cmd.mul_cube) begin
      mul_a = prod_r[TT_W-1:0];
      mul_b = W_W'(3 * EASE_SCALE) - {t, 1'b0};
    end else if (cmd.mul_range) begin
      mul_a = TT_W'(sm_r);
      mul_b = W_W'(span);
    end
  end

  assign prod_rnd_sm    = prod_r + (PROD_W'(1) << (2 * EASE_BITS - 1));
  assign prod_rnd_pulse = prod_r + (PROD_W'(1) << (EASE_BITS - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fc_r  <= fc_eff;
      lo_r  <= cfg.min_pulse_us;
      hi_r  <= hi_eff;
      num_r <= {phase_c, {EASE_BITS{1'b0}}} + NUM_W'(fc_eff >> 1);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? FC_W'(rem_sh - {1'b0, fc_r}) : rem_sh[FC_W-1:0];
    end
    if (cmd.mul_sq || cmd.mul_cube || cmd.mul_range) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.scale) begin
      sm_r <= T_W'(prod_rnd_sm >> (2 * EASE_BITS));
    end
    if (cmd.pulse) begin
      pulse_r <= lo_r + PULSE_W'(prod_rnd_pulse >> EASE_BITS);
    end
    if (cmd.load_out) begin
      hip_r   <= pulse_r;
      thigh_r <= lo_r + hi_r - pulse_r;
    end
  end

  // ping-pong step, clamped at both ends
  always_comb begin
    phase_nxt = phase_r;
    down_nxt  = down_r;
    if (cmd.load_out) begin
      if (down_r) begin
        if (phase_r > fc_r) begin
          phase_nxt = fc_r;
          down_nxt  = 1'b1;
        end else if (phase_r <= FC_W'(1)) begin
          phase_nxt = '0;
          down_nxt  = 1'b0;
        end else begin
          phase_nxt = phase_r - 1'b1;
        end
      end else begin
        if (({1'b0, phase_r} + 1'b1) >= {1'b0, fc_r}) begin
          phase_nxt = fc_r;
          down_nxt  = 1'b1;
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      down_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      down_r  <= down_nxt;
    end
  end

  assign hip_pulse_us   = hip_r;
  assign thigh_pulse_us = thigh_r;
  assign calf_pulse_us  = hip_r;

  `SMSS_ASSERT(a_t_bound, clk, rst_n, cmd.mul_sq |-> num_r <= NUM_W'(EASE_SCALE), "eased parameter above full scale")
  `SMSS_ASSERT(a_pulse_bound, clk, rst_n, cmd.load_out |-> pulse_r >= lo_r && pulse_r <= hi_r, "pulse outside min/max")
  `SMSS_ASSERT(a_mirror, clk, rst_n, cmd.load_out |=> hip_r + thigh_r == lo_r + hi_r, "thigh is not the mirror of hip")
  `SMSS_ASSERT(a_phase_clamp, clk, rst_n, cmd.load_out |=> phase_r <= fc_r, "phase stepped past frame count")

endmodule

### dv/tb_top.sv
module tb_top;
  import smss_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLDOFF_LEN   = 600;
  localparam int RAND_PHASES   = 15;
  localparam int TICKS_PER_PH  = 115;

  typedef struct packed {
    logic [PULSE_W-1:0] hip;
    logic [PULSE_W-1:0] thigh;
    logic [PULSE_W-1:0] calf;
  } pulse_set_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_tick = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PULSE_W-1:0]  out_hip_pulse_us;
  logic [PULSE_W-1:0]  out_thigh_pulse_us;
  logic [PULSE_W-1:0]  out_calf_pulse_us;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  smoothstep_servo_sweep dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_tick            (in_tick),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hip_pulse_us   (out_hip_pulse_us),
    .out_thigh_pulse_us (out_thigh_pulse_us),
    .out_calf_pulse_us  (out_calf_pulse_us),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the sweep: register copies plus phase/direction
  logic [FC_W-1:0]    frames_cfg = FRAME_COUNT_RST;
  logic [PULSE_W-1:0] min_cfg    = MIN_PULSE_RST;
  logic [PULSE_W-1:0] max_cfg    = MAX_PULSE_RST;
  int                 sweep_phase = 0;
  bit                 sweeping_down = 1'b0;

  bit         tick_queue[$];
  pulse_set_t pulse_q[$];
  int         errors = 0;
  bit         flood = 1'b0;
  bit         holdoff_req = 1'b0;
  bit         holdoff_ack = 1'b0;
  int         holdoff_left = 0;
  int         cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int eased_pulse_us(int ph, int fc, int lo, int hi);
    longint unsigned sc, p, t, sm, span;
    sc   = longint'(EASE_SCALE);
    p    = longint'((ph > fc) ? fc : ph);
    t    = (p * sc + longint'(fc / 2)) / longint'(fc);
    sm   = (t * t * (3 * sc - 2 * t) + (sc * sc) / 2) / (sc * sc);
    span = longint'(hi - lo);
    return lo + int'((span * sm + sc / 2) / sc);
  endfunction

  // expected pulses for one accepted tick, then advance the ping-pong phase
  task automatic sweep_tick();
    int fc, lo, hi, pulse, nxt;
    pulse_set_t want;
    fc    = (frames_cfg == 0) ? 1 : int'(frames_cfg);
    lo    = int'(min_cfg);
    hi    = (max_cfg < min_cfg) ? lo : int'(max_cfg);
    pulse = eased_pulse_us(sweep_phase, fc, lo, hi);
    want.hip   = PULSE_W'(pulse);
    want.thigh = PULSE_W'(lo + hi - pulse);
    want.calf  = PULSE_W'(pulse);
    pulse_q.push_back(want);
    nxt = sweep_phase + (sweeping_down ? -1 : 1);
    if (nxt >= fc) begin
      sweep_phase   = fc;
      sweeping_down = 1'b1;
    end else if (nxt <= 0) begin
      sweep_phase   = 0;
      sweeping_down = 1'b0;
    end else begin
      sweep_phase = nxt;
    end
  endtask

  // sender: bursts with random gaps, no gaps while flooding
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    bit took;
    took = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_tick  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        took = 1'b1;
        if (in_tick)
          sweep_tick();
      end
      if (!in_valid || took) begin
        if (gap_left != 0 && !flood) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_tick  <= tick_queue.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by a toggle of holdoff_req
  always @(posedge clk) begin
    if (holdoff_req != holdoff_ack) begin
      holdoff_ack  <= holdoff_req;
      holdoff_left <= HOLDOFF_LEN;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end
  end

  // receiver: check each beat, stall on a pattern that changes mode now and then
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    pulse_set_t want;
    bit pat;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pulse_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat hip=%0d thigh=%0d calf=%0d",
                                    out_hip_pulse_us, out_thigh_pulse_us,
                                    out_calf_pulse_us));
        end else begin
          want = pulse_q.pop_front();
          if (out_hip_pulse_us !== want.hip)
            report_mismatch($sformatf("hip got %0d want %0d", out_hip_pulse_us, want.hip));
          if (out_thigh_pulse_us !== want.thigh)
            report_mismatch($sformatf("thigh got %0d want %0d",
                                      out_thigh_pulse_us, want.thigh));
          if (out_calf_pulse_us !== want.calf)
            report_mismatch($sformatf("calf got %0d want %0d", out_calf_pulse_us, want.calf));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: pat = 1'b0;
        1: pat = ($urandom_range(0, 99) < 40);
        default: pat = ((cycles % 11) < 4);
      endcase
      out_stall <= pat || (holdoff_left != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input int val);
    logic [DATA_W-1:0] word;
    word = $urandom();
    case (idx)
      REG_FRAME_COUNT: word[FC_W-1:0] = FC_W'(val);
      default:         word[PULSE_W-1:0] = PULSE_W'(val);
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_COUNT: frames_cfg = word[FC_W-1:0];
      REG_MIN_PULSE:   min_cfg    = word[PULSE_W-1:0];
      default:         max_cfg    = word[PULSE_W-1:0];
    endcase
  endtask

  task automatic cfg_all(input int fc, input int mn, input int mx);
    cfg_write(REG_FRAME_COUNT, fc);
    cfg_write(REG_MIN_PULSE, mn);
    cfg_write(REG_MAX_PULSE, mx);
  endtask

  // pattern bits go out LSB first
  task automatic queue_ticks(input logic [31:0] pat, input int n);
    for (int i = 0; i < n; i++)
      tick_queue.push_back(pat[i]);
  endtask

  task automatic queue_random(input int n_ticks);
    int got;
    got = 0;
    while (got < n_ticks) begin
      if ($urandom_range(0, 9) == 0) begin
        tick_queue.push_back(1'b0);
      end else begin
        tick_queue.push_back(1'b1);
        got++;
      end
    end
  endtask

  task automatic wait_idle();
    while (tick_queue.size() != 0 || in_valid || pulse_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int fc, mn, mx, sel;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, with idle ticks mixed in
    queue_ticks(32'b11_0011_1011, 10);
    wait_idle();
    // frame count lowered below the current phase
    cfg_write(REG_FRAME_COUNT, 3);
    queue_ticks(32'h3f, 6);
    wait_idle();
    // zero frame count acts as one
    cfg_write(REG_FRAME_COUNT, 0);
    queue_ticks(32'h7, 3);
    wait_idle();
    // max below min collapses the range
    cfg_all(1023, 4095, 0);
    queue_ticks(32'h3, 2);
    wait_idle();
    cfg_all(1, 0, 4095);
    queue_ticks(32'h7, 3);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      sel = $urandom_range(0, 9);
      if (sel < 6)       fc = $urandom_range(1, 40);
      else if (sel == 6) fc = 1;
      else if (sel == 7) fc = 1023;
      else if (sel == 8) fc = 0;
      else               fc = $urandom_range(1, 1023);
      case ($urandom_range(0, 5))
        0: begin mn = 0;    mx = 4095; end
        1: begin mn = 4095; mx = 0;    end
        2: begin mn = $urandom_range(0, 4095); mx = $urandom_range(0, 4095); end
        3: begin mn = $urandom_range(0, 4095); mx = mn; end
        default: begin
          mn = $urandom_range(0, 2000);
          mx = $urandom_range(mn, 4095);
        end
      endcase
      cfg_all(fc, mn, mx);
      if (ph == 4) begin
        // back-to-back offers against a long output hold-off
        flood = 1'b1;
        @(posedge clk);
        holdoff_req <= ~holdoff_req;
      end
      queue_random(TICKS_PER_PH);
      wait_idle();
      flood = 1'b0;
    end

    if (pulse_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pulse_q.size()));
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/smss_pkg.sv
src/smss_regs.sv
src/smss_ctrl.sv
src/smss_dp.sv
src/smoothstep_servo_sweep.sv
dv/tb_top.sv
